// ===== hdl/ars_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_pkg: shared types and constants of the relative angle sensor
// Fixed-point formats, the CORDIC arctangent table and the command/status
// structs exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package ars_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int FRAC_BITS    = 16;

	// Angle accumulator format: degrees with 24 fraction bits.
	localparam int ANG_FRAC = 24;
	localparam int Z_W      = 34;
	// CORDIC vector width: 32-bit inputs plus pre-rotation and gain growth.
	localparam int X_W      = 35;

	localparam int TIME_W   = 63;
	localparam int IN_W     = 32;
	localparam int OUT_W    = 25;

	// Angle after rounding: sign, eight integer bits for 180, fraction.
	localparam int ANG_W    = FRAC_BITS + 9;
	localparam int REL_W    = (ANG_W + 1 > OUT_W) ? ANG_W + 1 : OUT_W;

	localparam int IT_W      = $clog2(CORDIC_STEPS);
	localparam int TAB_DEPTH = 32;
	localparam int TAB_IDX_W = $clog2(TAB_DEPTH);

	localparam int RND_SH = ANG_FRAC - FRAC_BITS;

	// atan(2^-i) in degrees, 24 fraction bits.
	localparam logic signed [Z_W-1:0] ATAN_TAB [TAB_DEPTH] = '{
		34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
		34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
		34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
		34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
		34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
		34'sd917,       34'sd458,       34'sd229,       34'sd115,
		34'sd57,        34'sd29,        34'sd14,        34'sd7,
		34'sd4,         34'sd2,         34'sd1,         34'sd0
	};

	typedef struct packed {
		logic            time_wr;   // store the tick time
		logic            load;      // load the CORDIC vector
		logic            step;      // one CORDIC iteration
		logic [IT_W-1:0] idx;       // iteration number
		logic            round;     // round and saturate the angle
		logic            finish;    // form the result and write the output register
		logic            zero_valid;
	} ars_cmd_t;

	typedef struct packed {
		logic time_back;   // tick time is earlier than the stored time
		logic out_free;    // output register can take a result
	} ars_sts_t;

endpackage

// ===== hdl/ars_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_if: channel interfaces of the relative angle sensor
// Input request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface ars_in_if;
	logic                              valid;
	logic                              ready;
	logic                              command;
	logic                              ready_flag;
	logic [ars_pkg::TIME_W-1:0]        tick_time;
	logic                              offset_valid;
	logic signed [ars_pkg::IN_W-1:0]   offset_x;
	logic signed [ars_pkg::IN_W-1:0]   offset_y;

	modport source (output valid, command, ready_flag, tick_time, offset_valid,
		offset_x, offset_y, input ready);
	modport sink (input valid, command, ready_flag, tick_time, offset_valid,
		offset_x, offset_y, output ready);
endinterface

interface ars_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [ars_pkg::OUT_W-1:0]  rel_heading;

	modport source (output valid, rel_heading, input ready);
	modport sink (input valid, rel_heading, output ready);
endinterface

interface ars_cfg_if;
	logic valid;
	logic ready;
	logic invert;

	modport source (output valid, invert, input ready);
	modport sink (input valid, invert, output ready);
endinterface

// ===== hdl/atan2_relative_angle_sensor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_relative_angle_sensor: relative heading from a planar frame offset
// A tick with a valid offset yields atan2(offset_y, offset_x) in degrees by
// an iterative CORDIC, measured against the first angle seen.
// ----------------------------------------------------------------------------
// A tick with a valid offset is loaded on acceptance and runs through the CORDIC
// iterations, rounding and the finish state, which waits for a free output
// register; other requests end at acceptance. The single shared CORDIC iteration
// stage takes one tick at a time; the output register lets the next one in early.
// Reset (arst_n low, asynchronous): disarmed, no zero reference, stored time 0,
// invert 0, no result pending.
module atan2_relative_angle_sensor (
	input  logic      clk,
	input  logic      arst_n,
	ars_in_if.sink    sample,
	ars_out_if.source result,
	ars_cfg_if.sink   cfg
);

	ars_pkg::ars_cmd_t cmd;
	ars_pkg::ars_sts_t sts;

	assign cfg.ready = 1'b1;

	ars_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (sample.valid),
		.in_ready     (sample.ready),
		.command      (sample.command),
		.ready_flag   (sample.ready_flag),
		.offset_valid (sample.offset_valid),
		.sts          (sts),
		.cmd          (cmd)
	);

	ars_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.tick_time   (sample.tick_time),
		.offset_x    (sample.offset_x),
		.offset_y    (sample.offset_y),
		.cfg_valid   (cfg.valid),
		.cfg_invert  (cfg.invert),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.rel_heading (result.rel_heading)
	);

endmodule

// ===== hdl/ars_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_ctrl: sequencing controller of the relative angle sensor
// Decodes requests, keeps the armed and zero-reference flags and steps the
// datapath through load, CORDIC iterations, rounding and result formation.
// ----------------------------------------------------------------------------
module ars_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              command,
	input  logic              ready_flag,
	input  logic              offset_valid,
	input  ars_pkg::ars_sts_t sts,
	output ars_pkg::ars_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ITER,
		ST_ROUND,
		ST_FINISH
	} state_t;

	localparam logic [ars_pkg::IT_W-1:0] LAST_IT = ars_pkg::IT_W'(ars_pkg::CORDIC_STEPS - 1);

	state_t                    state_q;
	logic [ars_pkg::IT_W-1:0]  cnt_q;
	logic                      armed_q;
	logic                      zero_valid_q;
	logic                      accept;
	logic                      tick_armed;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid & in_ready;
	assign tick_armed = accept & command & armed_q;

	always_comb begin
		cmd            = '0;
		cmd.time_wr    = tick_armed;
		cmd.load       = tick_armed & ~sts.time_back & offset_valid;
		cmd.step       = (state_q == ST_ITER);
		cmd.idx        = cnt_q;
		cmd.round      = (state_q == ST_ROUND);
		cmd.finish     = (state_q == ST_FINISH) & sts.out_free;
		cmd.zero_valid = zero_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			armed_q      <= 1'b0;
			zero_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !command && ready_flag) begin
						armed_q <= 1'b1;
					end else if (tick_armed) begin
						if (sts.time_back) begin
							// Clock went backwards: drop the zero reference and disarm.
							armed_q      <= 1'b0;
							zero_valid_q <= 1'b0;
						end else if (offset_valid) begin
							cnt_q   <= '0;
							state_q <= ST_ITER;
						end
					end
				end
				ST_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IT) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						zero_valid_q <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_iter_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER && cnt_q == LAST_IT) |=> (state_q == ST_ROUND))
		else $error("CORDIC iteration count did not end in the rounding state");

	a_round_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |=> (state_q == ST_FINISH))
		else $error("rounding state lasted more than one cycle");

	a_zero_latched: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (zero_valid_q && state_q == ST_IDLE))
		else $error("zero reference not latched after a result");

	a_back_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_armed && sts.time_back) |=> (!armed_q && !zero_valid_q && state_q == ST_IDLE))
		else $error("backwards clock did not disarm the block");

endmodule

// ===== hdl/ars_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ars_dp: datapath of the relative angle sensor
// Tick time register, vectoring CORDIC with one shared iteration stage,
// rounding and saturation, zero reference and the output register.
// ----------------------------------------------------------------------------
module ars_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ars_pkg::ars_cmd_t                cmd,
	output ars_pkg::ars_sts_t                sts,
	input  logic [ars_pkg::TIME_W-1:0]       tick_time,
	input  logic signed [ars_pkg::IN_W-1:0]  offset_x,
	input  logic signed [ars_pkg::IN_W-1:0]  offset_y,
	input  logic                             cfg_valid,
	input  logic                             cfg_invert,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [ars_pkg::OUT_W-1:0] rel_heading
);

	localparam logic signed [ars_pkg::Z_W-1:0] Z_NINETY =
		ars_pkg::Z_W'(90) << ars_pkg::ANG_FRAC;
	localparam logic signed [ars_pkg::Z_W-1:0] Z_RND =
		(ars_pkg::RND_SH > 0) ? (ars_pkg::Z_W'(1) << (ars_pkg::RND_SH - 1)) : '0;
	localparam logic signed [ars_pkg::Z_W-1:0] ANG_LIM =
		ars_pkg::Z_W'(180) << ars_pkg::FRAC_BITS;
	localparam logic signed [ars_pkg::REL_W-1:0] HALF =
		ars_pkg::REL_W'(180) << ars_pkg::FRAC_BITS;
	localparam logic signed [ars_pkg::REL_W-1:0] FULL = HALF <<< 1;

	logic [ars_pkg::TIME_W-1:0]        last_time_q;
	logic                              invert_q;
	logic                              out_valid_q;
	logic signed [ars_pkg::ANG_W-1:0]  zero_q;

	logic signed [ars_pkg::X_W-1:0]    x_q, y_q;
	logic signed [ars_pkg::Z_W-1:0]    z_q;
	logic                              zero_vec_q;
	logic signed [ars_pkg::ANG_W-1:0]  ang_q;
	logic signed [ars_pkg::OUT_W-1:0]  out_angle_q;

	logic signed [ars_pkg::X_W-1:0]    xe, ye, x_init, y_init, xs, ys;
	logic signed [ars_pkg::Z_W-1:0]    z_init, z_rnd, z_sat, tab_val;
	logic signed [ars_pkg::ANG_W-1:0]  zero_sel;
	logic signed [ars_pkg::REL_W-1:0]  rel_raw, rel_wrap, rel_out;

	assign sts = '{time_back: (tick_time < last_time_q), out_free: (~out_valid_q | out_ready)};

	// Pre-rotation by +/-90 degrees brings the vector into the right half plane.
	always_comb begin
		xe = ars_pkg::X_W'(offset_x);
		ye = ars_pkg::X_W'(offset_y);
		if (xe < 0) begin
			if (ye >= 0) begin
				x_init = ye;
				y_init = -xe;
				z_init = Z_NINETY;
			end else begin
				x_init = -ye;
				y_init = xe;
				z_init = -Z_NINETY;
			end
		end else begin
			x_init = xe;
			y_init = ye;
			z_init = '0;
		end
	end

	assign xs      = x_q >>> cmd.idx;
	assign ys      = y_q >>> cmd.idx;
	assign tab_val = ars_pkg::ATAN_TAB[ars_pkg::TAB_IDX_W'(cmd.idx)];

	always_comb begin
		z_rnd = (z_q + Z_RND) >>> ars_pkg::RND_SH;
		if (z_rnd > ANG_LIM) begin
			z_sat = ANG_LIM;
		end else if (z_rnd < -ANG_LIM) begin
			z_sat = -ANG_LIM;
		end else begin
			z_sat = z_rnd;
		end
	end

	// The first angle after the reference was dropped is its own zero.
	always_comb begin
		zero_sel = cmd.zero_valid ? zero_q : ang_q;
		rel_raw  = ars_pkg::REL_W'(ang_q) - ars_pkg::REL_W'(zero_sel);
		if (rel_raw > HALF) begin
			rel_wrap = rel_raw - FULL;
		end else if (rel_raw < -HALF) begin
			rel_wrap = rel_raw + FULL;
		end else begin
			rel_wrap = rel_raw;
		end
		rel_out = invert_q ? -rel_wrap : rel_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			invert_q    <= 1'b0;
			out_valid_q <= 1'b0;
			zero_q      <= '0;
		end else begin
			if (cmd.time_wr) begin
				last_time_q <= tick_time;
			end
			if (cfg_valid) begin
				invert_q <= cfg_invert;
			end
			if (cmd.finish && !cmd.zero_valid) begin
				zero_q <= ang_q;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q        <= x_init;
			y_q        <= y_init;
			z_q        <= z_init;
			zero_vec_q <= (offset_x == '0) && (offset_y == '0);
		end else if (cmd.step) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + tab_val;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - tab_val;
			end
		end
		if (cmd.round) begin
			ang_q <= zero_vec_q ? '0 : z_sat[ars_pkg::ANG_W-1:0];
		end
		if (cmd.finish) begin
			out_angle_q <= rel_out[ars_pkg::OUT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign rel_heading = out_angle_q;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for atan2_relative_angle_sensor
// Runs a short directed list of requests and then constrained-by-hand random
// traffic against a cycle-free model of the arming, clock and CORDIC heading
// logic. The sender idles and the receiver stalls at random in several
// phases, and the invert register is toggled between phases.
// ----------------------------------------------------------------------------
module tb;

	localparam bit CMD_READY = 1'b0;
	localparam bit CMD_TICK  = 1'b1;

	localparam int ANG_Q      = 24;
	localparam int SETTLE     = 30;
	localparam int STALL_MAX  = 4000;
	localparam int SMALL_OFS  = 1 << 19;

	localparam logic [ars_pkg::TIME_W-1:0] TIME_MAX = '1;
	localparam logic signed [ars_pkg::IN_W-1:0] OFS_MIN = 32'sh8000_0000;
	localparam logic signed [ars_pkg::IN_W-1:0] OFS_MAX = 32'sh7fff_ffff;
	localparam logic signed [ars_pkg::IN_W-1:0] ONE_M   = 32'sh0001_0000;

	// atan(2^-i) in degrees with 24 fraction bits
	localparam longint ATAN_DEG_Q24 [32] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
		58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
		14, 7, 4, 2, 1, 0
	};

	typedef struct {
		bit                                command;
		bit                                ready_flag;
		logic [ars_pkg::TIME_W-1:0]        tick_time;
		bit                                offset_valid;
		logic signed [ars_pkg::IN_W-1:0]   offset_x;
		logic signed [ars_pkg::IN_W-1:0]   offset_y;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ars_in_if  in_ch ();
	ars_out_if out_ch ();
	ars_cfg_if cfg_ch ();

	atan2_relative_angle_sensor i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (in_ch),
		.result (out_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sample_t                          pending_samples [$];
	logic signed [ars_pkg::OUT_W-1:0] expected_angles [$];
	int                               errors = 0;
	int                               idle_pct = 0;
	int                               stall_pct = 0;
	int                               quiet_cycles = 0;

	// Heading model state
	bit                           invert_q = 1'b0;
	bit                           armed_q = 1'b0;
	bit                           zero_valid_q = 1'b0;
	longint                       zero_angle_q = 0;
	logic [ars_pkg::TIME_W-1:0]   last_time_q = '0;

	// Stimulus-side view of arming and time, used only to shape sequences
	bit                           gen_armed = 1'b0;
	logic [ars_pkg::TIME_W-1:0]   gen_time = '0;

	function automatic longint atan2_degrees_q(longint y, longint x);
		longint z, t, xs, ys, lim;
		lim = longint'(180) <<< ars_pkg::FRAC_BITS;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = longint'(90) <<< ANG_Q;
			end else begin
				t = x; x = -y; y = t; z = -(longint'(90) <<< ANG_Q);
			end
		end
		for (int i = 0; i < ars_pkg::CORDIC_STEPS && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; z = z + ATAN_DEG_Q24[i];
			end else begin
				x = x - ys; y = y + xs; z = z - ATAN_DEG_Q24[i];
			end
		end
		if (ANG_Q > ars_pkg::FRAC_BITS)
			z = (z + (longint'(1) <<< (ANG_Q - ars_pkg::FRAC_BITS - 1)))
				>>> (ANG_Q - ars_pkg::FRAC_BITS);
		if (z > lim)
			z = lim;
		if (z < -lim)
			z = -lim;
		return z;
	endfunction

	function automatic bit predict_heading(input sample_t s,
			output logic signed [ars_pkg::OUT_W-1:0] angle);
		longint ang, rel, half;
		half = longint'(180) <<< ars_pkg::FRAC_BITS;
		angle = '0;
		if (s.command == CMD_READY) begin
			if (s.ready_flag)
				armed_q = 1'b1;
			return 1'b0;
		end
		if (!armed_q)
			return 1'b0;
		if (s.tick_time < last_time_q) begin
			zero_valid_q = 1'b0;
			armed_q = 1'b0;
			last_time_q = s.tick_time;
			return 1'b0;
		end
		last_time_q = s.tick_time;
		if (!s.offset_valid)
			return 1'b0;
		ang = atan2_degrees_q(longint'(s.offset_y), longint'(s.offset_x));
		if (!zero_valid_q) begin
			zero_angle_q = ang;
			zero_valid_q = 1'b1;
		end
		rel = ang - zero_angle_q;
		if (rel > half)
			rel = rel - 2 * half;
		else if (rel < -half)
			rel = rel + 2 * half;
		if (invert_q)
			rel = -rel;
		angle = ars_pkg::OUT_W'(rel);
		return 1'b1;
	endfunction

	function automatic logic [ars_pkg::TIME_W-1:0] rand_time();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[ars_pkg::TIME_W-1:0];
	endfunction

	function automatic logic signed [ars_pkg::IN_W-1:0] rand_offset();
		case ($urandom_range(7)) inside
			0: begin
				case ($urandom_range(4))
					0: return OFS_MIN;
					1: return OFS_MAX;
					2: return 0;
					3: return 1;
					default: return -1;
				endcase
			end
			[1:2]: return int'($urandom_range(0, 2 * SMALL_OFS)) - SMALL_OFS;
			default: return $urandom;
		endcase
	endfunction

	function automatic void push_ready(bit flag);
		pending_samples.push_back('{CMD_READY, flag, rand_time(), bit'($urandom_range(1)),
			$urandom, $urandom});
		if (flag)
			gen_armed = 1'b1;
	endfunction

	function automatic void push_tick(logic [ars_pkg::TIME_W-1:0] t, bit ok,
			logic signed [ars_pkg::IN_W-1:0] x, logic signed [ars_pkg::IN_W-1:0] y);
		pending_samples.push_back('{CMD_TICK, bit'($urandom_range(1)), t, ok, x, y});
		if (gen_armed) begin
			if (t < gen_time)
				gen_armed = 1'b0;
			gen_time = t;
		end
	endfunction

	function automatic logic [ars_pkg::TIME_W-1:0] next_time();
		logic [63:0] t;
		case ($urandom_range(49)) inside
			[0:4]: t = {1'b0, gen_time};
			[5:7]: t = {1'b0, gen_time} + $urandom;
			8: t = {1'b0, gen_time} + ({1'b0, rand_time()} % ({1'b0, TIME_MAX - gen_time} + 1));
			default: t = {1'b0, gen_time} + $urandom_range(1, 1000);
		endcase
		if (t > {1'b0, TIME_MAX})
			t = {1'b0, TIME_MAX};
		return t[ars_pkg::TIME_W-1:0];
	endfunction

	// Mostly armed runs of ticks with a rising clock; now and then a noise
	// event, or a clock step backwards followed by ticks that are dropped.
	function automatic void push_random_traffic(int count);
		int target;
		target = pending_samples.size() + count;
		while (pending_samples.size() < target) begin
			if (!gen_armed) begin
				if ($urandom_range(4) == 0)
					push_ready(1'b0);
				if ($urandom_range(3) == 0)
					push_tick(rand_time(), 1'b1, rand_offset(), rand_offset());
				push_ready(1'b1);
			end else begin
				case ($urandom_range(49)) inside
					[0:1]: push_ready(bit'($urandom_range(1)));
					2: begin
						if (gen_time != 0)
							push_tick(rand_time() % gen_time, bit'($urandom_range(1)),
								rand_offset(), rand_offset());
						else
							push_tick(next_time(), 1'b1, rand_offset(), rand_offset());
					end
					default: push_tick(next_time(), $urandom_range(9) != 0,
						rand_offset(), rand_offset());
				endcase
			end
		end
	endfunction

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || in_ch.valid || expected_angles.size() != 0);
	endtask

	task automatic write_invert(bit value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.invert <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(bit inv, int idle, int stall, int count);
		wait_quiet();
		repeat (SETTLE) @(posedge clk);
		write_invert(inv);
		@(negedge clk);
		idle_pct = idle;
		stall_pct = stall;
		push_random_traffic(count / 2);
		// The sender holds off here until every pending result is back.
		wait_quiet();
		push_random_traffic(count - count / 2);
	endtask

	always @(posedge clk) begin : driver
		sample_t                          acc;
		sample_t                          nxt;
		logic signed [ars_pkg::OUT_W-1:0] angle;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				acc = '{in_ch.command, in_ch.ready_flag, in_ch.tick_time,
					in_ch.offset_valid, in_ch.offset_x, in_ch.offset_y};
				if (predict_heading(acc, angle))
					expected_angles.push_back(angle);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = pending_samples.pop_front();
					in_ch.command <= nxt.command;
					in_ch.ready_flag <= nxt.ready_flag;
					in_ch.tick_time <= nxt.tick_time;
					in_ch.offset_valid <= nxt.offset_valid;
					in_ch.offset_x <= nxt.offset_x;
					in_ch.offset_y <= nxt.offset_y;
					in_ch.valid <= 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		logic signed [ars_pkg::OUT_W-1:0] want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_angles.size() == 0) begin
					errors++;
					$display("%0t: heading expected none, got %0d",
						$time, out_ch.rel_heading);
				end else begin
					want = expected_angles.pop_front();
					if (out_ch.rel_heading !== want) begin
						errors++;
						$display("%0t: heading expected %0d, got %0d",
							$time, want, out_ch.rel_heading);
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (cfg_ch.valid && cfg_ch.ready)
			invert_q <= cfg_ch.invert;
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_MAX) begin
			$display("atan2_relative_angle_sensor regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.command = CMD_READY;
		in_ch.ready_flag = 1'b0;
		in_ch.tick_time = '0;
		in_ch.offset_valid = 1'b0;
		in_ch.offset_x = '0;
		in_ch.offset_y = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.invert = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Ticks before arming are dropped and do not move the stored time.
		push_tick(5, 1'b1, ONE_M, 0);
		push_ready(1'b0);
		push_tick(6, 1'b1, ONE_M, ONE_M);
		push_ready(1'b1);
		push_ready(1'b1);
		push_tick(100, 1'b0, 7, 9);
		push_tick(100, 1'b1, ONE_M, 0);
		push_tick(200, 1'b1, 0, 0);
		push_tick(300, 1'b1, OFS_MIN, 0);
		push_tick(300, 1'b1, OFS_MIN, -1);
		push_tick(400, 1'b1, 0, OFS_MAX);
		push_tick(500, 1'b1, 0, OFS_MIN);
		push_tick(600, 1'b1, OFS_MAX, OFS_MAX);
		push_tick(700, 1'b1, -1, OFS_MIN);
		// Clock steps back: the zero reference is dropped and the block disarms.
		push_tick(650, 1'b1, ONE_M, ONE_M);
		push_tick(900, 1'b1, ONE_M, ONE_M);
		push_ready(1'b1);
		// New zero near +180 so that the following angles wrap around.
		push_tick(660, 1'b1, -ONE_M, 1);
		push_tick(670, 1'b1, -ONE_M, -1);
		push_tick(680, 1'b1, ONE_M, -ONE_M);
		push_tick(TIME_MAX, 1'b1, ONE_M, ONE_M);
		push_tick(TIME_MAX, 1'b1, OFS_MIN, OFS_MIN);

		run_phase(1'b1, 0, 0, 350);
		run_phase(1'b0, 55, 0, 350);
		run_phase(1'b1, 0, 55, 350);
		run_phase(1'b0, 17, 17, 350);

		wait_quiet();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("atan2_relative_angle_sensor regression: pass");
		else
			$display("atan2_relative_angle_sensor regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ars_pkg.sv
hdl/ars_if.sv
hdl/ars_ctrl.sv
hdl/ars_dp.sv
hdl/atan2_relative_angle_sensor.sv
bench/tb.sv
